/* src/hnt_pkg.sv */
// constants, types and hash helpers for the hashed node table
package hnt_pkg;

	// field widths
	localparam int CMD_W  = 2;
	localparam int WORD_W = 64;
	localparam int SLOT_W = 10;
	localparam int ENTRY_W = 2 * WORD_W;

	// packed stream widths, filled up to whole bytes
	localparam int S_FIELDS_W = CMD_W + 2 * WORD_W + SLOT_W;
	localparam int M_FIELDS_W = SLOT_W + 2 * WORD_W + 1;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	// default table size
	localparam int TABLE_DEPTH_DEFAULT = 1024;

	// hash constants: prime = 2^40 + 0x1b3
	localparam logic [WORD_W-1:0] HASH_SEED   = 64'hCBF2_9CE4_8422_2325;
	localparam int                PRIME_SHIFT = 40;
	localparam logic [8:0]        PRIME_LOW   = 9'h1B3;
	localparam int                ROT_FIRST   = 47;
	localparam int                ROT_SECOND  = 31;
	localparam int                FOLD_SHIFT  = 32;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_FIND  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	// rotate left by a constant amount
	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int r);
		return (v << r) | (v >> (WORD_W - r));
	endfunction

	// multiply by the prime modulo 2^64: one shift and one narrow product
	function automatic logic [WORD_W-1:0] mul_prime(input logic [WORD_W-1:0] v);
		logic [WORD_W+8:0] p;
		p = v * PRIME_LOW;
		return (v << PRIME_SHIFT) + p[WORD_W-1:0];
	endfunction

	// fold the upper half into the lower half
	function automatic logic [WORD_W-1:0] fold(input logic [WORD_W-1:0] v);
		return v ^ (v >> FOLD_SHIFT);
	endfunction

endpackage

/* src/hnt_ram.sv */
// generic simple dual-port ram with registered read
module hnt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/hashed_node_table_find_or_insert_top.sv */
// find-or-insert hash table with linear probing, top level
//
//  channel  dir  signals                        content
//  s_*      in   s_tvalid s_tready s_tdata      command, key or entry, slot index
//  m_*      out  m_tvalid m_tready m_tdata      result index, entry words, status
//
// after reset a clearing pass writes zero to every slot; no item is taken until it ends
// one item at a time; a find probes n slots, one slot per cycle through the ram read port,
// after the hash, with a constant remainder (three folds, quotient, remainder, correction)
// before the probe when TABLE_DEPTH is not a power of two
// the result sits in an output register; the next item is taken while it waits there
// a stalled output holds the finished result and the block waits before loading another
module hashed_node_table_find_or_insert_top #(
	parameter int TABLE_DEPTH = hnt_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// command, entry_high, entry_low, slot_index, zero fill
	input  logic [hnt_pkg::S_DATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// result_index, result_high, result_low, status, zero fill
	output logic [hnt_pkg::M_DATA_W-1:0] m_tdata
);

	import hnt_pkg::*;

	localparam int  IW        = $clog2(TABLE_DEPTH);
	localparam int  CW        = $clog2(TABLE_DEPTH + 1);
	localparam int  MOD_STEPS = 6;
	localparam int  MW        = $clog2(MOD_STEPS + 1);
	localparam bit  IS_POW2   = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

	// remainder constants: 2^32 mod depth and floor(2^33 / depth)
	localparam logic [31:0] MOD_R32   = 32'((64'd1 << 32) % TABLE_DEPTH);
	localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 33) / TABLE_DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_HASH3,
		ST_MOD,
		ST_PROBE,
		ST_RDWAIT,
		ST_RESP
	} state_t;

	state_t state_q;

	// input fields
	logic [CMD_W-1:0]  in_cmd;
	logic [WORD_W-1:0] in_high;
	logic [WORD_W-1:0] in_low;
	logic [SLOT_W-1:0] in_idx;
	logic [IW-1:0]     in_addr;
	logic              in_range;
	logic              s_accept;

	assign in_cmd   = s_tdata[CMD_W-1:0];
	assign in_high  = s_tdata[CMD_W +: WORD_W];
	assign in_low   = s_tdata[CMD_W + WORD_W +: WORD_W];
	assign in_idx   = s_tdata[CMD_W + 2 * WORD_W +: SLOT_W];
	assign in_addr  = IW'(in_idx);
	assign in_range = 32'(in_idx) < 32'(TABLE_DEPTH);
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// working registers
	logic [IW-1:0]     clr_q;
	logic [WORD_W-1:0] key_hi_q;
	logic [WORD_W-1:0] key_lo_q;
	logic [WORD_W-1:0] hash_q;
	logic [IW:0]       rem_q;
	logic [31:0]       quo_q;
	logic [MW-1:0]     mod_cnt_q;
	logic [IW-1:0]     pos_q;
	logic [CW-1:0]     issued_q;
	logic [CW-1:0]     ncheck_q;
	logic              chk_v_q;
	logic [IW-1:0]     chk_pos_q;

	// pending result
	logic [SLOT_W-1:0] res_idx_q;
	logic [WORD_W-1:0] res_hi_q;
	logic [WORD_W-1:0] res_lo_q;
	logic              res_status_q;

	// output register
	logic              m_tvalid_q;
	logic [SLOT_W-1:0] out_idx_q;
	logic [WORD_W-1:0] out_hi_q;
	logic [WORD_W-1:0] out_lo_q;
	logic              out_status_q;

	// ram port
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	hnt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// hash rounds and fold
	logic [WORD_W-1:0] round1;
	logic [WORD_W-1:0] round2;
	logic [WORD_W-1:0] folded;

	assign round1 = mul_prime(rotl(HASH_SEED ^ key_hi_q, ROT_FIRST));
	assign round2 = mul_prime(rotl(hash_q ^ key_lo_q, ROT_SECOND));
	assign folded = fold(hash_q);

	// remainder by the table depth: fold the upper word, then quotient by reciprocal
	logic [WORD_W-1:0] fold_prod;
	logic [WORD_W-1:0] fold_next;
	logic [WORD_W:0]   quo_prod;
	logic [IW:0]       rem_est;
	logic [IW:0]       rem_fix;

	assign fold_prod = {32'd0, hash_q[WORD_W-1:32]} * {32'd0, MOD_R32};
	assign fold_next = fold_prod + {32'd0, hash_q[31:0]};
	assign quo_prod  = {32'd0, hash_q[32:0]} * {33'd0, MOD_RECIP};
	// low bits suffice: the true remainder estimate is below twice the depth
	assign rem_est   = hash_q[IW:0] - quo_q[IW:0] * (IW+1)'(TABLE_DEPTH);
	assign rem_fix   = (rem_q >= (IW+1)'(TABLE_DEPTH)) ? rem_q - (IW+1)'(TABLE_DEPTH) : rem_q;

	// probe compare on the slot read last cycle
	logic          slot_empty;
	logic          slot_match;
	logic          probe_last;
	logic          probe_stop;
	logic          probe_issue;
	logic [IW-1:0] pos_next;

	assign slot_empty  = (ram_rdata == '0);
	assign slot_match  = (ram_rdata == {key_hi_q, key_lo_q});
	assign probe_last  = (ncheck_q == CW'(TABLE_DEPTH - 1));
	assign probe_stop  = chk_v_q && (slot_empty || slot_match || probe_last);
	assign probe_issue = !probe_stop && (issued_q != CW'(TABLE_DEPTH));
	assign pos_next    = (pos_q == IW'(TABLE_DEPTH - 1)) ? '0 : pos_q + 1'b1;

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// ram control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = pos_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				if (s_accept && in_range) begin
					if (in_cmd == CMD_READ) begin
						ram_re    = 1'b1;
						ram_raddr = in_addr;
					end
					if (in_cmd == CMD_WRITE) begin
						ram_we    = 1'b1;
						ram_waddr = in_addr;
						ram_wdata = {in_high, in_low};
					end
				end
			end
			ST_PROBE: begin
				if (chk_v_q && slot_empty) begin
					ram_we    = 1'b1;
					ram_waddr = chk_pos_q;
					ram_wdata = {key_hi_q, key_lo_q};
				end
				ram_re = probe_issue;
			end
			default: begin
			end
		endcase
	end

	// control state machine and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			key_hi_q     <= '0;
			key_lo_q     <= '0;
			hash_q       <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			mod_cnt_q    <= '0;
			pos_q        <= '0;
			issued_q     <= '0;
			ncheck_q     <= '0;
			chk_v_q      <= 1'b0;
			chk_pos_q    <= '0;
			res_idx_q    <= '0;
			res_hi_q     <= '0;
			res_lo_q     <= '0;
			res_status_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			out_idx_q    <= '0;
			out_hi_q     <= '0;
			out_lo_q     <= '0;
			out_status_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_RESP) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						key_hi_q     <= in_high;
						key_lo_q     <= in_low;
						res_idx_q    <= in_idx;
						res_hi_q     <= '0;
						res_lo_q     <= '0;
						res_status_q <= 1'b0;
						case (in_cmd)
							CMD_FIND: state_q <= ST_HASH1;
							CMD_READ: state_q <= in_range ? ST_RDWAIT : ST_RESP;
							default:  state_q <= ST_RESP;
						endcase
					end
				end
				ST_HASH1: begin
					hash_q  <= round1;
					state_q <= ST_HASH2;
				end
				ST_HASH2: begin
					hash_q  <= round2;
					state_q <= ST_HASH3;
				end
				ST_HASH3: begin
					issued_q <= '0;
					ncheck_q <= '0;
					chk_v_q  <= 1'b0;
					if (IS_POW2) begin
						pos_q   <= IW'(folded);
						state_q <= ST_PROBE;
					end else begin
						hash_q    <= folded;
						rem_q     <= '0;
						mod_cnt_q <= MW'(MOD_STEPS);
						state_q   <= ST_MOD;
					end
				end
				// three folds, then quotient, remainder and one correction
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q - 1'b1;
					if (mod_cnt_q > MW'(3)) begin
						hash_q <= fold_next;
					end else if (mod_cnt_q == MW'(3)) begin
						quo_q <= quo_prod[WORD_W:33];
					end else if (mod_cnt_q == MW'(2)) begin
						rem_q <= rem_est;
					end else begin
						pos_q   <= rem_fix[IW-1:0];
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (chk_v_q) begin
						if (probe_stop) begin
							if (slot_empty || slot_match) begin
								res_idx_q    <= SLOT_W'(chk_pos_q);
								res_status_q <= 1'b0;
							end else begin
								res_idx_q    <= '0;
								res_status_q <= 1'b1;
							end
							state_q <= ST_RESP;
						end else begin
							ncheck_q <= ncheck_q + 1'b1;
						end
					end
					// keep one read in flight while no hit has been seen
					if (probe_issue) begin
						pos_q     <= pos_next;
						issued_q  <= issued_q + 1'b1;
						chk_pos_q <= pos_q;
						chk_v_q   <= 1'b1;
					end else begin
						chk_v_q <= 1'b0;
					end
				end
				ST_RDWAIT: begin
					res_hi_q <= ram_rdata[ENTRY_W-1:WORD_W];
					res_lo_q <= ram_rdata[WORD_W-1:0];
					state_q  <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						out_idx_q    <= res_idx_q;
						out_hi_q     <= res_hi_q;
						out_lo_q     <= res_lo_q;
						out_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output packing
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_DATA_W - M_FIELDS_W)'(0), out_status_q, out_lo_q, out_hi_q, out_idx_q};

	// read and write never meet on one slot in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("ram read and write to the same slot");

	// the probe never checks more slots than the table holds
	a_probe_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_q |-> (ncheck_q < CW'(TABLE_DEPTH)))
		else $error("probe ran past the table size");

	// a full status comes with index and words at zero
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[SLOT_W + 2 * WORD_W]) |->
		(m_tdata[SLOT_W-1:0] == '0 && m_tdata[SLOT_W +: 2 * WORD_W] == '0))
		else $error("full status with nonzero payload");

	// the first probe cycle always starts a slot read
	a_probe_starts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_PROBE) |-> ram_re)
		else $error("probe entered without a read");

	// probe writes land only on the slot just checked
	a_probe_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && ram_we) |-> (chk_v_q && slot_empty))
		else $error("probe write without an empty slot");

endmodule
